[sv/rss_pkg.sv]
// Shared constants, instruction codes and request types of the RV32 subset step unit.
`default_nettype none
package rss_pkg;

    // Size of the byte memory; a power of two, so address wrap is a plain truncation.
    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [31:0] PC_RESET  = 32'h0000_1000;
    localparam logic [31:0] PC_INCR   = 32'd4;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Opcodes
    localparam logic [6:0] OP_ALU    = 7'h33;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;

    // Function fields
    localparam logic [6:0] F7_ADD = 7'h00;
    localparam logic [6:0] F7_SUB = 7'h20;
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_SW  = 3'd2;
    localparam logic [2:0] F3_BEQ = 3'd0;

    localparam logic [4:0] REG_ZERO = 5'd0;

    // Byte counter limits for word transfers over the byte port
    localparam logic [2:0] BYTE_LAST  = 3'd3;
    localparam logic [2:0] BYTE_DRAIN = 3'd4;

    typedef logic [MEM_AW-1:0] mem_addr_t;

    typedef struct packed {
        logic       we;
        logic       re;
        mem_addr_t  addr;
        logic [7:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic        re;
        logic [4:0]  ra1;
        logic [4:0]  ra2;
        logic        we;
        logic [4:0]  wa;
        logic [31:0] wd;
    } rf_req_t;

endpackage
`default_nettype wire

[sv/rss_ifs.sv]
// Valid/ready channel interfaces for items and results of the step unit.
`default_nettype none
interface rss_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] load_address;
    logic [7:0]  load_byte;

    modport source (output valid, output cmd, output load_address, output load_byte,
                    input ready);
    modport sink (input valid, input cmd, input load_address, input load_byte,
                  output ready);
endinterface

interface rss_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic [31:0] instruction;
    logic        unsupported;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;

    modport source (output valid, output next_pc, output instruction, output unsupported,
                    output reg_written, output dest_reg, output dest_value,
                    input ready);
    modport sink (input valid, input next_pc, input instruction, input unsupported,
                  input reg_written, input dest_reg, input dest_value,
                  output ready);
endinterface
`default_nettype wire

[sv/rv32_subset_step_unit.sv]
// Top level: item sequencer of the RV32 subset step unit (ADD, SUB, LW, SW, BEQ).
`default_nettype none
// The unit keeps a program counter (reset 0x1000), a 32-entry register file and a
// MEM_BYTES byte memory behind one byte-wide port with a registered read.
// After reset all MEM_BYTES bytes (65536 with the default size) are zero-filled
// one byte per cycle; no item transfer is taken until the fill is done.
// Each item goes into an input register and each result into an output register,
// so the next item transfers while a result still waits on the output side.
// Work per item, set by the single byte port of the memory: a load item writes one
// byte; ADD, SUB, BEQ, no-ops and unsupported opcodes fetch (4 byte reads plus
// drain), then read registers, execute and retire; LW adds 4 more byte reads plus
// drain and SW 4 byte writes. Stores and loads wrap byte by byte at the end of the
// memory, like fetches.
module rv32_subset_step_unit
    import rss_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rss_item_if.sink    item,
    rss_result_if.source result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_REGRD = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_STORE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // Control state
    state_t      state_reg, state_next;
    logic        hold_valid_reg, hold_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] pc_reg, pc_next;
    logic [2:0]  cnt_reg, cnt_next;

    // Payload
    logic        hold_cmd_reg, hold_cmd_next;
    logic [15:0] hold_addr_reg, hold_addr_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic [31:0] inst_reg, inst_next;
    logic [31:0] word_reg, word_next;
    mem_addr_t   base_reg, base_next;
    logic [31:0] res_pc_reg, res_pc_next;
    logic [31:0] res_inst_reg, res_inst_next;
    logic        res_unsup_reg, res_unsup_next;
    logic        res_wr_reg, res_wr_next;
    logic [4:0]  res_rd_reg, res_rd_next;
    logic [31:0] res_val_reg, res_val_next;
    logic [31:0] out_pc_reg, out_pc_next;
    logic [31:0] out_inst_reg, out_inst_next;
    logic        out_unsup_reg, out_unsup_next;
    logic        out_wr_reg, out_wr_next;
    logic [4:0]  out_rd_reg, out_rd_next;
    logic [31:0] out_val_reg, out_val_next;

    // Memory and register file hookup
    mem_req_t    mem_req;
    logic [7:0]  mem_rdata;
    logic        mem_busy;
    rf_req_t     rf_req;
    logic [31:0] rs1_data;
    logic [31:0] rs2_data;

    // Instruction fields
    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic        alu_wr;
    logic [31:0] alu_val;
    logic        slot_free;

    rss_byte_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    rss_regfile u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rf_req),
        .rd1   (rs1_data),
        .rd2   (rs2_data)
    );

    assign opcode = inst_reg[6:0];
    assign rd     = inst_reg[11:7];
    assign funct3 = inst_reg[14:12];
    assign funct7 = inst_reg[31:25];
    assign imm_i  = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imm_s  = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign imm_b  = {{19{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                     inst_reg[11:8], 1'b0};

    // Take a new item only into an empty input register and never during the zero fill.
    assign item.ready = !hold_valid_reg && !mem_busy;
    assign slot_free  = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg;
        pc_next         = pc_reg;
        cnt_next        = cnt_reg;
        hold_cmd_next   = hold_cmd_reg;
        hold_addr_next  = hold_addr_reg;
        hold_byte_next  = hold_byte_reg;
        inst_next       = inst_reg;
        word_next       = word_reg;
        base_next       = base_reg;
        res_pc_next     = res_pc_reg;
        res_inst_next   = res_inst_reg;
        res_unsup_next  = res_unsup_reg;
        res_wr_next     = res_wr_reg;
        res_rd_next     = res_rd_reg;
        res_val_next    = res_val_reg;
        out_pc_next     = out_pc_reg;
        out_inst_next   = out_inst_reg;
        out_unsup_next  = out_unsup_reg;
        out_wr_next     = out_wr_reg;
        out_rd_next     = out_rd_reg;
        out_val_next    = out_val_reg;
        mem_req         = '0;
        rf_req          = '0;
        alu_wr          = 1'b0;
        alu_val         = 32'h0;

        // Input register: capture a transfer.
        if (item.valid && item.ready)
        begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = item.cmd;
            hold_addr_next  = item.load_address;
            hold_byte_next  = item.load_byte;
        end

        // Output register: drop the result once it is taken.
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (hold_valid_reg)
                begin
                    hold_valid_next = 1'b0;
                    if (hold_cmd_reg == CMD_LOAD)
                    begin
                        mem_req.we     = 1'b1;
                        mem_req.addr   = mem_addr_t'(hold_addr_reg);
                        mem_req.wdata  = hold_byte_reg;
                        res_pc_next    = pc_reg;
                        res_inst_next  = 32'h0;
                        res_unsup_next = 1'b0;
                        res_wr_next    = 1'b0;
                        res_rd_next    = REG_ZERO;
                        res_val_next   = 32'h0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        base_next  = mem_addr_t'(pc_reg);
                        cnt_next   = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                // Issue byte reads 0..3; each byte lands in the next cycle.
                if (cnt_reg != BYTE_DRAIN)
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = base_reg + mem_addr_t'(cnt_reg);
                end
                if (cnt_reg != 3'd0)
                begin
                    inst_next = {mem_rdata, inst_reg[31:8]};
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == BYTE_DRAIN)
                begin
                    state_next = S_REGRD;
                end
            end
            S_REGRD:
            begin
                rf_req.re  = 1'b1;
                rf_req.ra1 = inst_reg[19:15];
                rf_req.ra2 = inst_reg[24:20];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_inst_next  = inst_reg;
                res_unsup_next = 1'b0;
                res_wr_next    = 1'b0;
                res_rd_next    = REG_ZERO;
                res_val_next   = 32'h0;
                pc_next        = pc_reg + PC_INCR;
                state_next     = S_DONE;
                unique case (opcode)
                    OP_ALU:
                    begin
                        if ((funct3 == F3_ADD) && (funct7 == F7_ADD))
                        begin
                            alu_wr  = 1'b1;
                            alu_val = rs1_data + rs2_data;
                        end
                        else if ((funct3 == F3_ADD) && (funct7 == F7_SUB))
                        begin
                            alu_wr  = 1'b1;
                            alu_val = rs1_data - rs2_data;
                        end
                    end
                    OP_LOAD:
                    begin
                        if (funct3 == F3_LW)
                        begin
                            // Value is filled in once all four bytes are in.
                            res_wr_next = (rd != REG_ZERO);
                            res_rd_next = rd;
                            base_next   = mem_addr_t'(rs1_data + imm_i);
                            cnt_next    = '0;
                            state_next  = S_LOAD;
                        end
                    end
                    OP_STORE:
                    begin
                        if (funct3 == F3_SW)
                        begin
                            base_next  = mem_addr_t'(rs1_data + imm_s);
                            word_next  = rs2_data;
                            cnt_next   = '0;
                            state_next = S_STORE;
                        end
                    end
                    OP_BRANCH:
                    begin
                        if ((funct3 == F3_BEQ) && (rs1_data == rs2_data))
                        begin
                            pc_next = pc_reg + imm_b;
                        end
                    end
                    default:
                    begin
                        res_unsup_next = 1'b1;
                    end
                endcase
                if (alu_wr && (rd != REG_ZERO))
                begin
                    res_wr_next  = 1'b1;
                    res_rd_next  = rd;
                    res_val_next = alu_val;
                end
                res_pc_next = pc_next;
            end
            S_LOAD:
            begin
                if (cnt_reg != BYTE_DRAIN)
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = base_reg + mem_addr_t'(cnt_reg);
                end
                if (cnt_reg != 3'd0)
                begin
                    word_next = {mem_rdata, word_reg[31:8]};
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == BYTE_DRAIN)
                begin
                    if (res_wr_reg)
                    begin
                        res_val_next = {mem_rdata, word_reg[31:8]};
                    end
                    else
                    begin
                        res_rd_next = REG_ZERO;
                    end
                    state_next = S_DONE;
                end
            end
            S_STORE:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = base_reg + mem_addr_t'(cnt_reg);
                mem_req.wdata = word_reg[7:0];
                word_next     = {8'h00, word_reg[31:8]};
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_reg == BYTE_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Retire: write back and hand the result to the output register.
                if (slot_free)
                begin
                    rf_req.we      = res_wr_reg;
                    rf_req.wa      = res_rd_reg;
                    rf_req.wd      = res_val_reg;
                    out_valid_next = 1'b1;
                    out_pc_next    = res_pc_reg;
                    out_inst_next  = res_inst_reg;
                    out_unsup_next = res_unsup_reg;
                    out_wr_next    = res_wr_reg;
                    out_rd_next    = res_rd_reg;
                    out_val_next   = res_val_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= PC_RESET;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            pc_reg         <= pc_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg  <= hold_cmd_next;
        hold_addr_reg <= hold_addr_next;
        hold_byte_reg <= hold_byte_next;
        inst_reg      <= inst_next;
        word_reg      <= word_next;
        base_reg      <= base_next;
        res_pc_reg    <= res_pc_next;
        res_inst_reg  <= res_inst_next;
        res_unsup_reg <= res_unsup_next;
        res_wr_reg    <= res_wr_next;
        res_rd_reg    <= res_rd_next;
        res_val_reg   <= res_val_next;
        out_pc_reg    <= out_pc_next;
        out_inst_reg  <= out_inst_next;
        out_unsup_reg <= out_unsup_next;
        out_wr_reg    <= out_wr_next;
        out_rd_reg    <= out_rd_next;
        out_val_reg   <= out_val_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_pc_reg;
    assign result.instruction = out_inst_reg;
    assign result.unsupported = out_unsup_reg;
    assign result.reg_written = out_wr_reg;
    assign result.dest_reg    = out_rd_reg;
    assign result.dest_value  = out_val_reg;

`ifndef SYNTH
    // No item is taken while the memory is still being zero-filled.
    a_no_take_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !item.ready)
        else $error("item taken during memory zero fill");

    // The sequencer never touches the memory during the zero fill.
    a_no_access_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !(mem_req.we || mem_req.re))
        else $error("memory access during zero fill");

    // A retiring item lands in the output register and the sequencer goes idle.
    a_retire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && slot_free |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("retire did not reach the output register");

    // A reported register write never names x0 and is reported as written.
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.reg_written |-> (result.dest_reg != REG_ZERO))
        else $error("register write reported for x0");
`endif

endmodule
`default_nettype wire

[sv/rss_byte_mem.sv]
// Byte-wide synchronous memory with a zero-fill sweep after reset.
`default_nettype none
module rss_byte_mem
    import rss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output logic [7:0]    rdata,
    output logic          busy
);

    logic [7:0] mem [MEM_BYTES];
    mem_addr_t  clr_addr_reg;
    mem_addr_t  clr_addr_next;
    logic       busy_reg;
    logic       busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + mem_addr_t'(1);
            if (clr_addr_reg == mem_addr_t'(MEM_BYTES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Zero fill wins over requests; none arrive while it runs.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

[sv/rss_regfile.sv]
// 32 x 32 register file: two registered read ports, one write port, valid bits for reset.
`default_nettype none
module rss_regfile
    import rss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire rf_req_t req,
    output logic [31:0]  rd1,
    output logic [31:0]  rd2
);

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] valid_next;

    // x0 is never marked valid, so it always reads as zero.
    always_comb
    begin
        valid_next = valid_reg;
        if (req.we && (req.wa != REG_ZERO))
        begin
            valid_next[req.wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we && (req.wa != REG_ZERO))
        begin
            mem[req.wa] <= req.wd;
        end
        if (req.re)
        begin
            rd1 <= valid_reg[req.ra1] ? mem[req.ra1] : 32'h0;
            rd2 <= valid_reg[req.ra2] ? mem[req.ra2] : 32'h0;
        end
    end

endmodule
`default_nettype wire

[bench/rv32_subset_step_unit_checker.sv]
// Checker of the RV32 subset step unit: shadow machine state, pending results, field compares.
module rv32_subset_step_unit_checker
    import rss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rss_item_if         item,
    rss_result_if       result,
    input  logic        end_check,
    output int unsigned fail_count
);

    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] instruction;
        logic        unsupported;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
    } step_result_t;

    logic [31:0]  shadow_pc;
    logic [31:0]  shadow_regs [32];
    logic [7:0]   shadow_mem [MEM_BYTES];
    step_result_t pending_results [$];
    step_result_t oldest;
    int unsigned  errors_seen;
    logic         leftovers_counted;

    assign fail_count = errors_seen;

    // Little-endian word access; each byte address wraps on its own.
    function automatic logic [31:0] read_word(input logic [31:0] addr);
        logic [31:0] word;
        word = '0;
        for (int i = 0; i < 4; i++)
            word[8*i +: 8] = shadow_mem[mem_addr_t'(addr + i)];
        return word;
    endfunction

    function automatic void write_word(input logic [31:0] addr, input logic [31:0] word);
        for (int i = 0; i < 4; i++)
            shadow_mem[mem_addr_t'(addr + i)] = word[8*i +: 8];
    endfunction

    // Apply one item to the shadow state and return the result it must produce.
    function automatic step_result_t execute_item(input logic cmd, input logic [15:0] addr,
                                                  input logic [7:0] data);
        step_result_t res;
        logic [31:0]  inst;
        logic [31:0]  va;
        logic [31:0]  vb;
        logic [31:0]  wval;
        logic [4:0]   rd;
        logic [2:0]   f3;
        logic [6:0]   f7;
        logic         wr;
        logic         taken;
        res = '0;
        if (cmd == CMD_LOAD) begin
            shadow_mem[mem_addr_t'(addr)] = data;
            res.next_pc = shadow_pc;
            return res;
        end
        inst  = read_word(shadow_pc);
        rd    = inst[11:7];
        f3    = inst[14:12];
        f7    = inst[31:25];
        va    = shadow_regs[inst[19:15]];
        vb    = shadow_regs[inst[24:20]];
        wval  = '0;
        wr    = 1'b0;
        taken = 1'b0;
        case (inst[6:0])
            OP_ALU:
                if (f3 == F3_ADD && f7 == F7_ADD) begin
                    wval = va + vb;
                    wr   = 1'b1;
                end else if (f3 == F3_ADD && f7 == F7_SUB) begin
                    wval = va - vb;
                    wr   = 1'b1;
                end
            OP_LOAD:
                if (f3 == F3_LW) begin
                    wval = read_word(va + {{20{inst[31]}}, inst[31:20]});
                    wr   = 1'b1;
                end
            OP_STORE:
                if (f3 == F3_SW)
                    write_word(va + {{20{inst[31]}}, inst[31:25], inst[11:7]}, vb);
            OP_BRANCH:
                if (f3 == F3_BEQ && va == vb) begin
                    shadow_pc = shadow_pc + {{19{inst[31]}}, inst[31], inst[7], inst[30:25],
                                             inst[11:8], 1'b0};
                    taken = 1'b1;
                end
            default:
                res.unsupported = 1'b1;
        endcase
        if (!taken)
            shadow_pc = shadow_pc + PC_INCR;
        if (wr && rd != REG_ZERO) begin
            shadow_regs[rd] = wval;
            res.reg_written = 1'b1;
            res.dest_reg    = rd;
            res.dest_value  = wval;
        end
        res.next_pc     = shadow_pc;
        res.instruction = inst;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_pc = PC_RESET;
            for (int r = 0; r < 32; r++)
                shadow_regs[r] = '0;
            for (int unsigned a = 0; a < MEM_BYTES; a++)
                shadow_mem[a] = '0;
            pending_results.delete();
            errors_seen       = 0;
            leftovers_counted = 1'b0;
        end else begin
            if (item.valid && item.ready)
                pending_results.push_back(execute_item(item.cmd, item.load_address,
                                                       item.load_byte));
            if (result.valid && result.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer, next_pc %h", result.next_pc);
                    errors_seen++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("next_pc", oldest.next_pc, result.next_pc);
                    check_field("instruction", oldest.instruction, result.instruction);
                    check_field("unsupported", 32'(oldest.unsupported), 32'(result.unsupported));
                    check_field("reg_written", 32'(oldest.reg_written), 32'(result.reg_written));
                    check_field("dest_reg", 32'(oldest.dest_reg), 32'(result.dest_reg));
                    check_field("dest_value", oldest.dest_value, result.dest_value);
                end
            end
            if (end_check && !leftovers_counted) begin
                leftovers_counted = 1'b1;
                if (pending_results.size() != 0) begin
                    $error("%0d results never arrived", pending_results.size());
                    errors_seen += pending_results.size();
                end
            end
        end
    end

endmodule

[bench/rv32_subset_step_unit_tb.sv]
// Testbench top of the RV32 subset step unit: clock, reset, item stimulus, stalls, verdict.
module rv32_subset_step_unit_tb;
    import rss_pkg::*;

    // Run shape. The limit covers the zero-fill after reset plus every item at its
    // slowest (LW) with gaps and stalls, several times over.
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned IDLE_PERCENT = 9;
    // Item counts between which neither side idles.
    localparam int unsigned STEADY_FROM  = 900;
    localparam int unsigned STEADY_TO    = 1200;

    // Instruction kinds of the random part; well-formed kinds may still get a bad funct.
    typedef enum int unsigned {
        PICK_ADD,
        PICK_SUB,
        PICK_LW,
        PICK_SW,
        PICK_BEQ,
        PICK_UNKNOWN
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        steady = 1'b0;
    logic        end_check;
    int unsigned items_sent = 0;
    int unsigned results_seen;
    int unsigned cycle_count = 0;
    int unsigned fail_count;
    logic [31:0] last_pc;

    rss_item_if   item_ch ();
    rss_result_if result_ch ();

    rv32_subset_step_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rv32_subset_step_unit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .end_check  (end_check),
        .fail_count (fail_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rv32_subset_step_unit_tb: done, errors");
            $finish;
        end
    end

    // Count result transfers and keep the latest pc; the stimulus places code there.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
            last_pc      <= PC_RESET;
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            results_seen <= results_seen + 1;
            last_pc      <= result_ch.next_pc;
        end
    end

    // Stall the result side at random, except through the steady stretch.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] opc);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [6:0] opc);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], opc};
    endfunction

    // Favor x0 and a handful of low registers so results feed later instructions.
    function automatic logic [4:0] pick_reg();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return REG_ZERO;
        if (roll < 70)
            return 5'($urandom_range(1, 7));
        return 5'($urandom);
    endfunction

    function automatic logic [31:0] random_instruction();
        pick_t       pick;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] word;
        pick = pick_t'($urandom_range(0, PICK_UNKNOWN));
        rs1  = pick_reg();
        rs2  = pick_reg();
        case (pick)
            PICK_ADD: word = enc_r(F7_ADD, rs2, rs1, F3_ADD, pick_reg(), OP_ALU);
            PICK_SUB: word = enc_r(F7_SUB, rs2, rs1, F3_ADD, pick_reg(), OP_ALU);
            PICK_LW:  word = enc_i(12'($urandom), rs1, F3_LW, pick_reg(), OP_LOAD);
            PICK_SW:  word = enc_s(12'($urandom), rs2, rs1, F3_SW, OP_STORE);
            PICK_BEQ:
            begin
                // Compare a register with itself half the time, so the branch is taken.
                if ($urandom_range(1))
                    rs2 = rs1;
                word = enc_b({12'($urandom), 1'b0}, rs2, rs1, F3_BEQ, OP_BRANCH);
            end
            default:
            begin
                word = $urandom;
                do
                    word[6:0] = 7'($urandom);
                while (word[6:0] == OP_ALU || word[6:0] == OP_LOAD ||
                       word[6:0] == OP_STORE || word[6:0] == OP_BRANCH);
            end
        endcase
        // Corrupt funct3/funct7 of a known opcode now and then: the step becomes a no-op.
        // A nonzero offset on funct3 always misses the one accepted code; any funct7
        // with its low bit set is neither ADD nor SUB.
        if (pick != PICK_UNKNOWN && $urandom_range(99) < 15)
            case (word[6:0])
                OP_ALU:
                    if ($urandom_range(1))
                        word[14:12] = F3_ADD + 3'($urandom_range(1, 7));
                    else
                        word[31:25] = 7'($urandom) | 7'h01;
                OP_LOAD:   word[14:12] = F3_LW + 3'($urandom_range(1, 7));
                OP_STORE:  word[14:12] = F3_SW + 3'($urandom_range(1, 7));
                OP_BRANCH: word[14:12] = F3_BEQ + 3'($urandom_range(1, 7));
                default:   ;
            endcase
        return word;
    endfunction

    // Offer one item, idling first at random; hold valid until the transfer.
    task automatic send_item(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.cmd          <= cmd;
        item_ch.load_address <= addr;
        item_ch.load_byte    <= data;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    // Drop valid and hold until every transferred item has its result back.
    task automatic wait_results();
        if (results_seen != items_sent)
        begin
            item_ch.valid <= 1'b0;
            while (results_seen != items_sent)
                @(posedge clk);
        end
    endtask

    // Write an instruction at the current pc, byte by byte, then step it.
    task automatic run_instruction(input logic [31:0] inst);
        logic [15:0] base;
        wait_results();
        base = last_pc[15:0];
        for (int i = 0; i < 4; i++)
            send_item(CMD_LOAD, base + 16'(i), inst[8*i +: 8]);
        send_item(CMD_STEP, 16'($urandom), 8'($urandom));
    endtask

    initial
    begin : stimulus
        int unsigned goal;
        int unsigned roll;
        int unsigned burst;
        logic [15:0] noise_addr;

        rst_n                <= 1'b0;
        end_check            <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.cmd          <= CMD_LOAD;
        item_ch.load_address <= '0;
        item_ch.load_byte    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Items wait out the zero-fill on their own through ready.
        // Put all ones in the last memory byte, then step the empty memory: opcode 0
        // is unsupported and only advances pc.
        send_item(CMD_LOAD, 16'hFFFF, 8'hFF);
        send_item(CMD_STEP, 16'h0000, 8'h00);
        // Load from address -1: the word wraps round the end of memory.
        run_instruction(enc_i(12'hFFF, REG_ZERO, F3_LW, 5'd1, OP_LOAD));
        // Negate it into x2 so the upper bits are all ones.
        run_instruction(enc_r(F7_SUB, 5'd1, REG_ZERO, F3_ADD, 5'd2, OP_ALU));
        // Store at address -2, wrapping as well.
        run_instruction(enc_s(12'hFFE, 5'd2, REG_ZERO, F3_SW, OP_STORE));
        // Taken branch by the most negative offset, then by -18 to land pc below zero.
        run_instruction(enc_b(13'h1000, REG_ZERO, REG_ZERO, F3_BEQ, OP_BRANCH));
        run_instruction(enc_b(13'h1FEE, REG_ZERO, REG_ZERO, F3_BEQ, OP_BRANCH));
        // The fetch there wraps; the ADD targets x0 and must write nothing.
        run_instruction(enc_r(F7_ADD, 5'd2, 5'd2, F3_ADD, REG_ZERO, OP_ALU));

        // Random part: mostly instructions placed at pc, plus re-runs of whatever code
        // sits there and bursts of data bytes, often near the windows reached from x0.
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            steady <= (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
            roll = $urandom_range(99);
            if (roll < 60)
                run_instruction(random_instruction());
            else if (roll < 75)
                send_item(CMD_STEP, 16'($urandom), 8'($urandom));
            else
            begin
                burst      = $urandom_range(1, 4);
                noise_addr = 16'($urandom);
                if ($urandom_range(1))
                    noise_addr = {{5{noise_addr[15]}}, noise_addr[10:0]};
                for (int i = 0; i < burst; i++)
                    send_item(CMD_LOAD, noise_addr + 16'(i), 8'($urandom));
            end
        end

        // Drain, let the block settle, then count what never came back.
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("rv32_subset_step_unit_tb: done, clean");
        else
            $display("rv32_subset_step_unit_tb: done, errors");
        $finish;
    end

endmodule
